### hw/rtl/angular_point_in_polygon_test_assert.svh
// Assertion macros shared by the angular point-in-polygon test RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ANGULAR_POINT_IN_POLYGON_TEST_ASSERT_SVH
`define ANGULAR_POINT_IN_POLYGON_TEST_ASSERT_SVH

// Clocked assertion, disabled while reset is active.
`define APIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define APIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/apip_pkg.sv
// Package for the angular point-in-polygon test: widths, angle constants,
// arctangent table and the edge-pair queue entry type. No dependencies.
`timescale 1ns / 1ps

package apip_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int ACC_BITS   = 32;
    localparam int VEC_BITS   = 36;   // 33-bit difference plus CORDIC growth
    localparam int ITER_BITS  = 5;
    localparam int ROUND_SH   = ACC_BITS - ANGLE_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ANGLE_BITS:0]   FULL_TURN = (ANGLE_BITS + 1)'(64'd1 << ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));
    localparam logic [ANGLE_BITS-1:0] SMALL_ARC =
        ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd100) / 64'd200);
    localparam logic [ACC_BITS-1:0]   ROUND_ADD = ACC_BITS'((64'd1 << ROUND_SH) >> 1);
    localparam logic [ACC_BITS-1:0]   ACC_HALF  = ACC_BITS'(64'd1 << (ACC_BITS - 1));

    typedef struct packed {
        logic                  last;
        logic [ANGLE_BITS-1:0] a2;
        logic [ANGLE_BITS-1:0] a1;
    } edge_pair_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_BITS-1:0] atan_lookup(input logic [ITER_BITS-1:0] i);
        logic [ACC_BITS-1:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] adiff(input logic [ANGLE_BITS-1:0] from,
                                                   input logic [ANGLE_BITS-1:0] to);
        return ANGLE_BITS'(to - from);
    endfunction

endpackage

### hw/rtl/apip_front.sv
// Front end: accepts an edge, runs both endpoint vectors through two iterative
// CORDIC lanes (one step per cycle) and pushes the angle pair. Uses apip_pkg.
`timescale 1ns / 1ps

module apip_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [191:0]               in_data,
    input  logic                       in_last,
    output logic                       push,
    output apip_pkg::edge_pair_t       push_data,
    input  logic                       queue_full
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [apip_pkg::ITER_BITS-1:0] iter_reg, iter_next;
    logic last_reg;

    logic signed [apip_pkg::VEC_BITS-1:0] x_reg [2];
    logic signed [apip_pkg::VEC_BITS-1:0] y_reg [2];
    logic [apip_pkg::ACC_BITS-1:0]        acc_reg [2];
    logic                                 zero_reg [2];

    logic signed [apip_pkg::VEC_BITS-1:0] x_load [2];
    logic signed [apip_pkg::VEC_BITS-1:0] y_load [2];
    logic [apip_pkg::ACC_BITS-1:0]        acc_load [2];
    logic                                 zero_load [2];
    logic signed [apip_pkg::VEC_BITS-1:0] x_step [2];
    logic signed [apip_pkg::VEC_BITS-1:0] y_step [2];
    logic [apip_pkg::ACC_BITS-1:0]        acc_step [2];
    logic [apip_pkg::ANGLE_BITS-1:0]      angle [2];

    logic accept;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic signed [32:0] dx, dy, px, py;
        logic signed [apip_pkg::VEC_BITS-1:0] xs, ys;
        logic [apip_pkg::ACC_BITS-1:0] t, rnd;
        px = 33'(signed'(in_data[159:128]));
        py = 33'(signed'(in_data[191:160]));
        t  = apip_pkg::atan_lookup(iter_reg);
        for (int l = 0; l < 2; l++)
        begin
            dx = 33'(signed'(in_data[64*l +: 32])) - px;
            dy = 33'(signed'(in_data[64*l + 32 +: 32])) - py;
            zero_load[l] = (dx == '0) && (dy == '0);
            if (dx < 0)
            begin
                x_load[l]   = -apip_pkg::VEC_BITS'(dx);
                y_load[l]   = -apip_pkg::VEC_BITS'(dy);
                acc_load[l] = apip_pkg::ACC_HALF;
            end
            else
            begin
                x_load[l]   = apip_pkg::VEC_BITS'(dx);
                y_load[l]   = apip_pkg::VEC_BITS'(dy);
                acc_load[l] = '0;
            end
            xs = x_reg[l] >>> iter_reg;
            ys = y_reg[l] >>> iter_reg;
            if (y_reg[l] >= 0)
            begin
                x_step[l]   = x_reg[l] + ys;
                y_step[l]   = y_reg[l] - xs;
                acc_step[l] = acc_reg[l] + t;
            end
            else
            begin
                x_step[l]   = x_reg[l] - ys;
                y_step[l]   = y_reg[l] + xs;
                acc_step[l] = acc_reg[l] - t;
            end
            rnd = acc_reg[l] + apip_pkg::ROUND_ADD;
            angle[l] = zero_reg[l] ? '0 :
                apip_pkg::ANGLE_BITS'(rnd >> apip_pkg::ROUND_SH);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    iter_next  = '0;
                end
            end
            ST_RUN:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == '1)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!queue_full)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            last_reg <= in_last;
        for (int l = 0; l < 2; l++)
        begin
            if (accept)
            begin
                x_reg[l]    <= x_load[l];
                y_reg[l]    <= y_load[l];
                acc_reg[l]  <= acc_load[l];
                zero_reg[l] <= zero_load[l];
            end
            else if (state_reg == ST_RUN)
            begin
                x_reg[l]   <= x_step[l];
                y_reg[l]   <= y_step[l];
                acc_reg[l] <= acc_step[l];
            end
        end
    end

    assign push           = (state_reg == ST_PUSH) && !queue_full;
    assign push_data.a1   = angle[0];
    assign push_data.a2   = angle[1];
    assign push_data.last = last_reg;

endmodule

### hw/rtl/apip_queue.sv
// Two-entry queue of angle pairs between the front and back ends.
// Uses apip_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "angular_point_in_polygon_test_assert.svh"

module apip_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  apip_pkg::edge_pair_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output apip_pkg::edge_pair_t head
);

    apip_pkg::edge_pair_t entry_reg [apip_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'(apip_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `APIP_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
    `APIP_ASSERT(a_no_underflow, pop |-> not_empty, "pop from empty queue")
    `APIP_ASSERT_ALWAYS(a_count_range, count_reg <= 2'(apip_pkg::QUEUE_DEPTH),
        "queue count out of range")

endmodule

### hw/rtl/apip_back.sv
// Back end: merges each angle pair into the kept interval and delivers the
// inside verdict on the last edge through an output register. Uses apip_pkg.
`timescale 1ns / 1ps

module apip_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  apip_pkg::edge_pair_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_inside
);

    localparam int AB = apip_pkg::ANGLE_BITS;

    logic          started_reg;
    logic [AB-1:0] low_reg, high_reg, low_next, high_next;
    logic          valid_reg, inside_reg;
    logic          slot_free;

    assign slot_free = !valid_reg || out_ready;
    assign pop       = head_valid && (!head.last || slot_free);

    always_comb
    begin
        logic [AB-1:0] p1, p2, s1, s2, s3, s4, s5;
        logic [AB:0]   s6, s7;
        if (apip_pkg::adiff(head.a1, head.a2) < apip_pkg::HALF_TURN)
        begin
            p1 = head.a1;
            p2 = head.a2;
        end
        else
        begin
            p1 = head.a2;
            p2 = head.a1;
        end
        s1 = apip_pkg::adiff(low_reg, p1);
        s2 = apip_pkg::adiff(low_reg, p2);
        s3 = apip_pkg::adiff(high_reg, p1);
        s4 = apip_pkg::adiff(high_reg, p2);
        s5 = apip_pkg::adiff(low_reg, high_reg);
        s6 = apip_pkg::FULL_TURN - (AB + 1)'(s5);
        s7 = apip_pkg::FULL_TURN - (AB + 1)'(s2);
        low_next  = low_reg;
        high_next = high_reg;
        priority if (!started_reg)
        begin
            low_next  = p1;
            high_next = p2;
        end
        else if (s1 <= s5 && s2 <= s5)
        begin
            // pair inside the interval; backwards means it closes the circle
            if (s1 > s2)
            begin
                high_next = '0;
                low_next  = apip_pkg::SMALL_ARC;
            end
        end
        else if (s1 >= s5 && s2 <= s5)
            low_next = p1;
        else if ((AB + 1)'(s3) >= s6 && (AB + 1)'(s4) <= s6)
            high_next = p2;
        else if (s3 <= s4)
        begin
            if ((AB + 1)'(s3) >= s7)
                low_next = p1;
            else
                high_next = p2;
        end
        else
        begin
            low_next  = p1;
            high_next = p2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            low_reg     <= '0;
            high_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop && head.last)
            begin
                started_reg <= 1'b0;
                low_reg     <= '0;
                high_reg    <= '0;
                valid_reg   <= 1'b1;
            end
            else
            begin
                if (pop)
                begin
                    started_reg <= 1'b1;
                    low_reg     <= low_next;
                    high_reg    <= high_next;
                end
                if (out_ready)
                    valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
            inside_reg <= apip_pkg::adiff(low_next, high_next) > apip_pkg::HALF_TURN;
    end

    assign out_valid  = valid_reg;
    assign out_inside = inside_reg;

endmodule

### hw/rtl/angular_point_in_polygon_test.sv
// Angular point-in-polygon test, top level: front CORDIC angle unit, pair
// queue and interval merge back end. Uses apip_pkg and the apip_* modules.
//
// Usage: feed one polygon edge per s_ tvalid/tready transfer, with the test
// point repeated on every edge and s_tlast set on the final edge. The
// transfer of a final edge yields exactly one m_ transfer carrying the
// verdict (1 = inside); other edges yield nothing.
// Edges are taken one at a time: each is accepted, run through 32 CORDIC
// steps and pushed to the queue before s_tready rises again; both endpoints
// step together under one iteration counter, which sets the edge rate.
// The two-entry queue lets the front start the next edge while the back
// still waits on the receiver. If m_tready stays low, the verdict is held,
// the queue fills and s_tready then stays low until it drains.
// Reset (rst_n low, asynchronous) empties the queue, drops any pending
// verdict and clears the kept interval.
`timescale 1ns / 1ps

module angular_point_in_polygon_test (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // edge_start_x, edge_start_y, edge_end_x, edge_end_y, point_x, point_y
    input  logic [191:0] s_tdata,
    input  logic         s_tlast,   // last_edge
    output logic         m_tvalid,
    input  logic         m_tready,
    // inside_res, bits 7:1 zero
    output logic [7:0]   m_tdata
);

    logic                 push, full, pop, not_empty, verdict;
    apip_pkg::edge_pair_t push_data, head;

    apip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_data  (push_data),
        .queue_full (full)
    );

    apip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    apip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_inside (verdict)
    );

    assign m_tdata = {7'd0, verdict};

endmodule

### tb/angular_point_in_polygon_test_tb.sv
// Self-checking bench for angular_point_in_polygon_test: drives random and
// directed polygon edges, predicts each inside/outside verdict. Uses apip_pkg.
`timescale 1ns / 1ps

class verdict_scoreboard;
    bit                           started;
    logic [apip_pkg::ANGLE_BITS-1:0] lo, hi;
    bit                           verdicts[$];
    int                           errors;

    function void clear();
        started = 0;
        lo = '0;
        hi = '0;
    endfunction

    // CORDIC vectoring angle of (dx,dy), rounded to ANGLE_BITS
    function logic [apip_pkg::ANGLE_BITS-1:0] vector_angle(longint dx, longint dy);
        longint xs, ys;
        logic [31:0] acc;
        logic [32:0] rnd;
        const logic [31:0] atan_units[32] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
        acc = '0;
        if (dx == 0 && dy == 0)
            return '0;
        if (dx < 0)
        begin
            dx = -dx;
            dy = -dy;
            acc = 32'h80000000;
        end
        for (int i = 0; i < 32; i++)
        begin
            xs = dx >>> i;   // arithmetic shift floors
            ys = dy >>> i;
            if (dy >= 0)
            begin
                dx += ys;
                dy -= xs;
                acc += atan_units[i];
            end
            else
            begin
                dx -= ys;
                dy += xs;
                acc -= atan_units[i];
            end
        end
        rnd = {1'b0, acc} + apip_pkg::ROUND_ADD;
        return rnd[31:apip_pkg::ROUND_SH];
    endfunction

    function logic [apip_pkg::ANGLE_BITS-1:0] arc(logic [apip_pkg::ANGLE_BITS-1:0] f,
                                                 logic [apip_pkg::ANGLE_BITS-1:0] t);
        return t - f;
    endfunction

    function void note_edge(logic [191:0] d, bit last_edge);
        longint px, py;
        logic [apip_pkg::ANGLE_BITS-1:0] a1, a2, p1, p2;
        logic [apip_pkg::ANGLE_BITS:0] s1, s2, s3, s4, s5, s6, s7;
        px = longint'($signed(d[159:128]));
        py = longint'($signed(d[191:160]));
        a1 = vector_angle(longint'($signed(d[31:0])) - px, longint'($signed(d[63:32])) - py);
        a2 = vector_angle(longint'($signed(d[95:64])) - px, longint'($signed(d[127:96])) - py);
        if (arc(a1, a2) < apip_pkg::HALF_TURN)
        begin
            p1 = a1;
            p2 = a2;
        end
        else
        begin
            p1 = a2;
            p2 = a1;
        end
        if (!started)
        begin
            lo = p1;
            hi = p2;
            started = 1;
        end
        else
        begin
            s1 = arc(lo, p1);
            s2 = arc(lo, p2);
            s3 = arc(hi, p1);
            s4 = arc(hi, p2);
            s5 = arc(lo, hi);
            s6 = apip_pkg::FULL_TURN - s5;
            s7 = apip_pkg::FULL_TURN - s2;
            if (s1 <= s5 && s2 <= s5)
            begin
                if (s1 > s2)
                begin
                    hi = '0;
                    lo = apip_pkg::SMALL_ARC;
                end
            end
            else if (s1 >= s5 && s2 <= s5)
                lo = p1;
            else if (s3 >= s6 && s4 <= s6)
                hi = p2;
            else if (s3 <= s4)
            begin
                if (s3 >= s7)
                    lo = p1;
                else
                    hi = p2;
            end
            else
            begin
                lo = p1;
                hi = p2;
            end
        end
        if (last_edge)
        begin
            verdicts.push_back(arc(lo, hi) > apip_pkg::HALF_TURN);
            clear();
        end
    endfunction

    function void check_verdict(logic [7:0] got);
        bit want;
        if (verdicts.size() == 0)
        begin
            $error("unexpected verdict %0h", got);
            errors++;
            return;
        end
        want = verdicts.pop_front();
        if (got[0] !== want)
        begin
            $error("inside_res expected %0d got %0d", want, got[0]);
            errors++;
        end
        if (got[7:1] !== 7'd0)
        begin
            $error("pad expected 0 got %0h", got[7:1]);
            errors++;
        end
    endfunction
endclass

module angular_point_in_polygon_test_tb;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    verdict_scoreboard sb;
    int  idle_cycles;
    int  out_wait;
    int  rx_gap;
    bit  feed_done;

    angular_point_in_polygon_test dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    task automatic send_edge(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                             logic [31:0] ey, logic [31:0] px, logic [31:0] py, bit last);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {py, px, ey, ex, sy, sx};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_edge({py, px, ey, ex, sy, sx}, last);
    endtask

    // near-regular polygon (jittered vertex angles) around a center, point inside or outside
    task automatic send_polygon();
        int n;
        int rad;
        real cx, cy, th;
        logic [31:0] vx[$], vy[$], px, py;
        n = $urandom_range(3, 8);
        rad = $urandom_range(1, 1000);
        cx = $itor($signed($urandom_range(0, 2000)) - 1000);
        cy = $itor($signed($urandom_range(0, 2000)) - 1000);
        for (int k = 0; k < n; k++)
        begin
            th = 6.283185307 * k / n + 0.3 * ($urandom_range(0, 100) / 100.0);
            vx.push_back(32'($rtoi((cx + rad * $cos(th)) * 65536.0)));
            vy.push_back(32'($rtoi((cy + rad * $sin(th)) * 65536.0)));
        end
        px = 32'($rtoi((cx + rad * ($urandom_range(0, 300) / 100.0 - 1.5)) * 65536.0));
        py = 32'($rtoi((cy + rad * ($urandom_range(0, 300) / 100.0 - 1.5)) * 65536.0));
        for (int k = 0; k < n; k++)
            send_edge(vx[k], vy[k], vx[(k + 1) % n], vy[(k + 1) % n], px, py, k == n - 1);
    endtask

    // receiver: draws a random wait before accepting each verdict
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_gap = $urandom_range(0, 4);
            out_wait <= rx_gap;
            m_tready <= (rx_gap == 0);
        end
        else if (m_tvalid && m_tready)
        begin
            sb.check_verdict(m_tdata);
            rx_gap = $urandom_range(0, 4);
            out_wait <= rx_gap;
            m_tready <= (rx_gap == 0);
        end
        else if (m_tvalid && out_wait != 0)
        begin
            out_wait <= out_wait - 1;
            m_tready <= (out_wait == 1);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("angular_point_in_polygon_test: mismatch");
            $finish;
        end
    end

    initial
    begin
        int sent, wait_cnt;
        logic [31:0] e, z;
        sb = new();
        sb.clear();
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tlast  = 0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, zero vectors, single-edge and degenerate polygons
        e = 32'h7FFFFFFF;
        z = 32'h80000000;
        send_edge(z, z, e, e, z, z, 1);
        send_edge(e, z, z, e, e, e, 1);
        send_edge(0, 0, 0, 0, 0, 0, 1);
        send_edge(1, 0, 0, 1, 0, 0, 0);
        send_edge(0, 1, -1, 0, 0, 0, 0);
        send_edge(-1, 0, 0, -1, 0, 0, 0);
        send_edge(0, -1, 1, 0, 0, 0, 1);
        send_edge(1, 0, -1, 0, 0, 0, 0);
        send_edge(-1, 0, 1, 0, 0, 0, 1);
        send_edge(e, e, z, z, 0, 0, 0);
        send_edge(z, e, e, z, 0, 0, 0);
        send_edge(1, 1, 2, 2, 0, 0, 1);
        send_edge(z, e, z, z, e, 0, 1);
        sent = 13;
        while (sent < 1900)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_polygon();
                sent += 5;
            end
            else
            begin
                send_edge(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), $urandom_range(0, 2) == 0);
                sent++;
            end
        end
        send_edge(0, 0, 1, 1, 5, 5, 1);
        s_tvalid <= 0;
        wait_cnt = 0;
        while (sb.verdicts.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (80) @(posedge clk);
        if (sb.errors == 0 && sb.verdicts.size() == 0)
            $display("angular_point_in_polygon_test: match");
        else
            $display("angular_point_in_polygon_test: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/apip_pkg.sv
hw/rtl/apip_front.sv
hw/rtl/apip_queue.sv
hw/rtl/apip_back.sv
hw/rtl/angular_point_in_polygon_test.sv
tb/angular_point_in_polygon_test_tb.sv
